// ----- rtl/rod_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rod_pkg;

  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 4;

  localparam logic [4:0] RED_MAX = 5'h1F;
  localparam logic [5:0] GREEN_MAX = 6'h3F;
  localparam logic [4:0] BLUE_MAX = 5'h1F;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic [1:0] {
    REG_RECT_LEFT     = 2'd0,
    REG_RECT_TOP      = 2'd1,
    REG_RECT_WIDTH    = 2'd2,
    REG_DITHER_ENABLE = 2'd3
  } reg_index_t;

  // 4x4 Bayer threshold matrix, addressed by {row, column}.
  function automatic logic [3:0] bayer_entry(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] entry;
    case ({row, col})
      4'd0:    entry = 4'd0;
      4'd1:    entry = 4'd8;
      4'd2:    entry = 4'd2;
      4'd3:    entry = 4'd10;
      4'd4:    entry = 4'd12;
      4'd5:    entry = 4'd4;
      4'd6:    entry = 4'd14;
      4'd7:    entry = 4'd6;
      4'd8:    entry = 4'd3;
      4'd9:    entry = 4'd11;
      4'd10:   entry = 4'd1;
      4'd11:   entry = 4'd9;
      4'd12:   entry = 4'd15;
      4'd13:   entry = 4'd7;
      4'd14:   entry = 4'd13;
      4'd15:   entry = 4'd5;
      default: entry = 4'd0;
    endcase
    return entry;
  endfunction

  // Bits 0, 1 and 2 of the entry bump red, green and blue by one, saturating.
  function automatic pixel_t dither_pixel(input pixel_t c, input logic [3:0] entry);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    if (r < 5'd2 && g < 6'd4 && b < 5'd2) begin
      return c;
    end
    if (entry[0] && r != RED_MAX) begin
      r = r + 5'd1;
    end
    if (entry[1] && g != GREEN_MAX) begin
      g = g + 6'd1;
    end
    if (entry[2] && b != BLUE_MAX) begin
      b = b + 5'd1;
    end
    return {r, g, b};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rod_pixel_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rod_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;
  logic        rect_start;

  modport source (output valid, output pixel_in, output rect_start, input ready);
  modport sink (input valid, input pixel_in, input rect_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/rod_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rod_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/rod_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rod_regs
  import rod_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output logic      [COORD_BITS-1:0]    rect_left,
  output logic      [COORD_BITS-1:0]    rect_top,
  output logic      [COORD_BITS:0]      rect_width,
  output logic                          dither_enable
);

  reg_index_t reg_index;
  logic       write_en;

  assign reg_index = reg_index_t'(paddr[3:2]);
  assign write_en  = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= (COORD_BITS+1)'(1);
      dither_enable <= 1'b1;
    end else if (write_en) begin
      case (reg_index)
        REG_RECT_LEFT:     rect_left     <= pwdata[COORD_BITS-1:0];
        REG_RECT_TOP:      rect_top      <= pwdata[COORD_BITS-1:0];
        REG_RECT_WIDTH:    rect_width    <= pwdata[COORD_BITS:0];
        REG_DITHER_ENABLE: dither_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_RECT_LEFT:     prdata = CFG_DATA_BITS'(rect_left);
      REG_RECT_TOP:      prdata = CFG_DATA_BITS'(rect_top);
      REG_RECT_WIDTH:    prdata = CFG_DATA_BITS'(rect_width);
      REG_DITHER_ENABLE: prdata = CFG_DATA_BITS'(dither_enable);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rgb565_ordered_dither_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// RGB565 4x4 ordered dither. Pixels of a rectangle arrive in row-major order on
// the pixels channel, one word per cycle unless stalled; rect_start marks the
// first pixel of a rectangle and restarts the column counter and row phase.
// Each pixel's screen position (rect_left plus column, rect_top plus row, both
// modulo 4) selects a Bayer entry whose low three bits add one to red, green
// and blue, saturating. Near-black pixels and all pixels with dither_enable
// clear pass unchanged. Throughput is one pixel per clock unless the output
// stalls; a result is registered in the cycle after acceptance. The input stays
// ready while the output register is empty or being drained in the same cycle.
// Registers (APB, byte addresses): 0x0 rect_left, 0x4 rect_top,
// 0x8 rect_width (0 acts as 1), 0xC dither_enable. Write only while idle.

module rgb565_ordered_dither_top
  import rod_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  rod_pixel_if.sink                     pixels,
  rod_result_if.source                  results,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam logic [COORD_BITS:0] WIDTH_MAX = (COORD_BITS+1)'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] rect_left;
  logic [COORD_BITS-1:0] rect_top;
  logic [COORD_BITS:0]   rect_width;
  logic                  dither_enable;

  logic [COORD_BITS-1:0] column_offset;
  logic [1:0]            row_phase;
  logic                  out_valid;
  pixel_t                pixel_out;

  logic [COORD_BITS-1:0] col_cur;
  logic [1:0]            row_cur;
  logic [COORD_BITS:0]   col_step;
  logic [COORD_BITS:0]   width_eff;
  logic                  row_wrap;
  logic [1:0]            px_col;
  logic [1:0]            px_row;
  pixel_t                pixel_next;
  logic                  accept;

  rod_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_width    (rect_width),
    .dither_enable (dither_enable)
  );

  assign pixels.ready      = !rst && (!out_valid || results.ready);
  assign accept            = pixels.valid && pixels.ready;
  assign results.valid     = out_valid;
  assign results.pixel_out = pixel_out;

  // A start word restarts the position before its own pixel is dithered.
  assign col_cur  = pixels.rect_start ? '0 : column_offset;
  assign row_cur  = pixels.rect_start ? 2'd0 : row_phase;
  assign col_step = {1'b0, col_cur} + (COORD_BITS+1)'(1);

  always_comb begin
    if (rect_width == '0) begin
      width_eff = (COORD_BITS+1)'(1);
    end else if (rect_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = rect_width;
    end
  end

  assign row_wrap = col_step >= width_eff;
  assign px_col   = rect_left[1:0] + col_cur[1:0];
  assign px_row   = rect_top[1:0] + row_cur;

  always_comb begin
    if (dither_enable) begin
      pixel_next = dither_pixel(pixels.pixel_in, bayer_entry(px_row, px_col));
    end else begin
      pixel_next = pixels.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= '0;
      row_phase     <= 2'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        if (row_wrap) begin
          column_offset <= '0;
          row_phase     <= row_cur + 2'd1;
        end else begin
          column_offset <= col_step[COORD_BITS-1:0];
          row_phase     <= row_cur;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_out <= pixel_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rod_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rod_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [15:0] pixel_in,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] pixel_out
);

  logic in_accept;
  assign in_accept = in_valid && in_ready;

  // A result word waiting on a stalled sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out))
    else $error("result word changed while stalled");

  // An empty output register never blocks the input once reset has been released.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rst && !out_valid |-> in_ready)
    else $error("input not ready with output register empty");

  // Every accepted pixel yields a result in the following cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted pixel produced no result");

  // Each channel is either unchanged or raised by exactly one.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    in_accept |=>
      (pixel_out[15:11] == $past(pixel_in[15:11]) ||
       pixel_out[15:11] == $past(pixel_in[15:11]) + 5'd1) &&
      (pixel_out[10:5] == $past(pixel_in[10:5]) ||
       pixel_out[10:5] == $past(pixel_in[10:5]) + 6'd1) &&
      (pixel_out[4:0] == $past(pixel_in[4:0]) ||
       pixel_out[4:0] == $past(pixel_in[4:0]) + 5'd1))
    else $error("channel moved by more than one step");

  // Near-black pixels pass untouched.
  a_near_black: assert property (@(posedge clk) disable iff (rst)
    in_accept && pixel_in[15:12] == 4'd0 && pixel_in[10:7] == 4'd0 &&
      pixel_in[4:1] == 4'd0 |=> pixel_out == $past(pixel_in))
    else $error("near-black pixel was altered");

endmodule

bind rgb565_ordered_dither_top rod_checker u_rod_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .pixel_in  (pixels.pixel_in),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .pixel_out (results.pixel_out)
);

`default_nettype wire
